// ----- hdl/bmw_pkg.sv -----
// Shared constants and register codes for the binary morphology window.
package bmw_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int KMAX       = 5;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int WIN_BITS  = KMAX * KMAX;
  localparam int LINE_BITS = KMAX - 1;

  // fixed field widths
  localparam int OUT_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int K_W       = 3;
  localparam int MASK_W    = 25;
  localparam int MASK_IDX_W = $clog2(MASK_W);
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam int ROW_CALC_W = (ROW_W > OUT_W) ? ROW_W : OUT_W;
  localparam int COL_CALC_W = (COL_W > OUT_W) ? COL_W : OUT_W;

  localparam logic OP_ERODE  = 1'b0;
  localparam logic OP_DILATE = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_HEIGHT = 3'd2,
    REG_KERNEL_WIDTH  = 3'd3,
    REG_ANCHOR_ROW    = 3'd4,
    REG_ANCHOR_COL    = 3'd5,
    REG_KERNEL_MASK   = 3'd6,
    REG_OPERATION     = 3'd7
  } bmw_reg_t;

endpackage

// ----- hdl/binary_morphology_window.sv -----
// Streaming binary erosion/dilation over a KMAX x KMAX window with line memory.
//
//  channel | ports                                  | direction | request moves
//  --------+----------------------------------------+-----------+-----------------------------
//  in      | in_valid, in_ready, in_pixel_on        | sink      | one pixel, raster order
//  out     | out_valid, out_ready, out_row, out_col,| source    | one decided output pixel
//          | out_on, out_last_window                |           |
//  cfg     | cfg_psel .. cfg_pready (APB)           | slave     | one register write or read
//
// Cycles: one pixel per clock while the output is not stalled. A pixel reads
//   its column of the line memory at acceptance; in the next cycle the slice is
//   built, and when the slice stage retires it is written back, shifted into the
//   window and, for an eligible pixel, the result registered and out_valid raised.
// Line memory: one synchronous RAM of MAX_WIDTH x (KMAX-1) bits, one read and
//   one write port. A back-to-back write/read of the same column (image width
//   of one) is forwarded from the write data.
// Reset: counters, window and config go to reset values at once. The memory
//   is not swept; a fill count marks the columns written since reset and
//   unwritten columns read as zero, so there is no clearing pass.
// Stalls: a stalled output holds; one pixel can sit in the slice stage behind
//   it, and in_ready drops only when both are occupied.
module binary_morphology_window (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_pixel_on,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bmw_pkg::OUT_W-1:0]   out_row,
  output logic [bmw_pkg::OUT_W-1:0]   out_col,
  output logic                        out_on,
  output logic                        out_last_window,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bmw_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [bmw_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [bmw_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import bmw_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] image_width_r, image_height_r;
  logic [K_W-1:0]    kernel_height_r, kernel_width_r, anchor_row_r, anchor_col_r;
  logic [MASK_W-1:0] kernel_mask_r;
  logic              operation_r;

  bmw_reg_t cfg_idx;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = bmw_reg_t'(cfg_paddr[ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= SIZE_W'(640);
      image_height_r  <= SIZE_W'(480);
      kernel_height_r <= K_W'(3);
      kernel_width_r  <= K_W'(3);
      anchor_row_r    <= K_W'(1);
      anchor_col_r    <= K_W'(1);
      kernel_mask_r   <= MASK_W'(511);
      operation_r     <= OP_ERODE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_KERNEL_HEIGHT: kernel_height_r <= cfg_pwdata[K_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width_r  <= cfg_pwdata[K_W-1:0];
        REG_ANCHOR_ROW:    anchor_row_r    <= cfg_pwdata[K_W-1:0];
        REG_ANCHOR_COL:    anchor_col_r    <= cfg_pwdata[K_W-1:0];
        REG_KERNEL_MASK:   kernel_mask_r   <= cfg_pwdata[MASK_W-1:0];
        REG_OPERATION:     operation_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:   cfg_prdata = DATA_W'(image_width_r);
      REG_IMAGE_HEIGHT:  cfg_prdata = DATA_W'(image_height_r);
      REG_KERNEL_HEIGHT: cfg_prdata = DATA_W'(kernel_height_r);
      REG_KERNEL_WIDTH:  cfg_prdata = DATA_W'(kernel_width_r);
      REG_ANCHOR_ROW:    cfg_prdata = DATA_W'(anchor_row_r);
      REG_ANCHOR_COL:    cfg_prdata = DATA_W'(anchor_col_r);
      REG_KERNEL_MASK:   cfg_prdata = DATA_W'(kernel_mask_r);
      REG_OPERATION:     cfg_prdata = DATA_W'(operation_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Saturated geometry (the user must keep config static while pixels flow; the block does not enforce it)
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] w_last;   // image width - 1
  logic [ROW_W-1:0] h_last;   // image height - 1
  logic [K_W-1:0]   kh_m1, kw_m1, ar_sat, ac_sat;

  always_comb begin
    if (image_width_r == '0)                  w_last = '0;
    else if (int'(image_width_r) > MAX_WIDTH) w_last = COL_W'(MAX_WIDTH - 1);
    else                                      w_last = COL_W'(image_width_r - 1'b1);

    if (image_height_r == '0)                   h_last = '0;
    else if (int'(image_height_r) > MAX_HEIGHT) h_last = ROW_W'(MAX_HEIGHT - 1);
    else                                        h_last = ROW_W'(image_height_r - 1'b1);

    if (kernel_height_r == '0)           kh_m1 = '0;
    else if (int'(kernel_height_r) > KMAX) kh_m1 = K_W'(KMAX - 1);
    else                                 kh_m1 = kernel_height_r - 1'b1;

    if (kernel_width_r == '0)            kw_m1 = '0;
    else if (int'(kernel_width_r) > KMAX) kw_m1 = K_W'(KMAX - 1);
    else                                 kw_m1 = kernel_width_r - 1'b1;

    ar_sat = (anchor_row_r > kh_m1) ? kh_m1 : anchor_row_r;
    ac_sat = (anchor_col_r > kw_m1) ? kw_m1 : anchor_col_r;
  end

  // Mask remapped to window bit order: slice d (d pixels back), row k above.
  logic [WIN_BITS-1:0] wmask_nxt, wmask_r;

  always_comb begin
    int d, k, idx;
    wmask_nxt = '0;
    for (d = 0; d < KMAX; d++) begin
      for (k = 0; k < KMAX; k++) begin
        idx = (int'(kh_m1) - k) * KMAX + (int'(kw_m1) - d);
        if (d <= int'(kw_m1) && k <= int'(kh_m1) && idx < MASK_W) begin
          wmask_nxt[d*KMAX + k] = kernel_mask_r[idx[MASK_IDX_W-1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wmask_r <= wmask_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept, position counters, line memory read
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic [COL_W:0]   fill_r, fill_nxt;    // columns [0, fill) written since reset
  logic             in_acc;
  logic             row_end, frame_end, elig;
  logic [OUT_W-1:0] orow0, ocol0;

  // slice stage
  logic              s1_v_r, s1_fire;
  logic              s1_pix_r, s1_hit_r, s1_fwd_r, s1_elig_r, s1_last_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [LINE_BITS-1:0] s1_fwd_line_r;
  logic [OUT_W-1:0]  s1_orow_r, s1_ocol_r;

  // output register
  logic              out_v_r;

  logic [LINE_BITS-1:0] line_mem [MAX_WIDTH];
  logic [LINE_BITS-1:0] line_rd_r, line_in;
  logic [KMAX-1:0]      slice;
  logic [WIN_BITS-1:0]  window_r, window_nxt;

  assign s1_fire  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_fire;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    row_end   = col_count_r >= w_last;
    frame_end = row_end && (row_count_r >= h_last);
    elig      = (row_count_r >= ROW_W'(kh_m1)) && (col_count_r >= COL_W'(kw_m1));
    orow0 = OUT_W'(ROW_CALC_W'(row_count_r) - ROW_CALC_W'(kh_m1) + ROW_CALC_W'(ar_sat));
    ocol0 = OUT_W'(COL_CALC_W'(col_count_r) - COL_CALC_W'(kw_m1) + COL_CALC_W'(ac_sat));

    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (in_acc) begin
      priority if (frame_end) begin
        row_count_nxt = '0;
        col_count_nxt = '0;
      end else if (row_end) begin
        row_count_nxt = row_count_r + 1'b1;
        col_count_nxt = '0;
      end else begin
        col_count_nxt = col_count_r + 1'b1;
      end
    end

    fill_nxt = fill_r;
    if (s1_fire && ({1'b0, s1_col_r} == fill_r)) fill_nxt = fill_r + 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: build slice, write line memory back, shift window, decide
  // ---------------------------------------------------------------------------
  always_comb begin
    if (s1_fwd_r)      line_in = s1_fwd_line_r;
    else if (s1_hit_r) line_in = line_rd_r;
    else               line_in = '0;
    slice      = {line_in, s1_pix_r};
    window_nxt = {window_r[WIN_BITS-KMAX-1:0], slice};
  end

  logic all_set, any_set;
  assign all_set = &(~wmask_r | window_nxt);
  assign any_set = |(wmask_r & window_nxt);

  // line memory: read on accept, write when the slice stage retires
  always_ff @(posedge clk) begin
    if (s1_fire) line_mem[s1_col_r] <= slice[LINE_BITS-1:0];
    if (in_acc)  line_rd_r <= line_mem[col_count_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
      fill_r      <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      window_r    <= '0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      fill_r      <= fill_nxt;
      if (in_acc)       s1_v_r <= 1'b1;
      else if (s1_fire) s1_v_r <= 1'b0;
      if (s1_fire) window_r <= window_nxt;
      if (s1_fire && s1_elig_r) out_v_r <= 1'b1;
      else if (out_ready)       out_v_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r      <= in_pixel_on;
      s1_col_r      <= col_count_r;
      s1_hit_r      <= {1'b0, col_count_r} < fill_r;
      s1_fwd_r      <= s1_fire && (s1_col_r == col_count_r);
      s1_fwd_line_r <= slice[LINE_BITS-1:0];
      s1_elig_r     <= elig;
      s1_last_r     <= frame_end;
      s1_orow_r     <= orow0;
      s1_ocol_r     <= ocol0;
    end
    if (s1_fire && s1_elig_r) begin
      out_row         <= s1_orow_r;
      out_col         <= s1_ocol_r;
      out_on          <= (operation_r == OP_DILATE) ? any_set : all_set;
      out_last_window <= s1_last_r;
    end
  end

  assign out_valid = out_v_r;

endmodule
